### rtl/core/assert_macros.svh
// Assertion macros shared by the execute core RTL.
// No dependencies; included inside module bodies that hold checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CHK_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("check failed: same-cycle implication");

// Next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("check failed: next-cycle implication");

`endif

### rtl/core/mse_pkg.sv
// Shared types and constants of the MIPS subset execute core.
// No dependencies; imported by mips_subset_execute.
package mse_pkg;

   // Primary opcodes
   localparam logic [5:0] OP_RTYPE = 6'h00;
   localparam logic [5:0] OP_J     = 6'h02;
   localparam logic [5:0] OP_JAL   = 6'h03;
   localparam logic [5:0] OP_BEQ   = 6'h04;
   localparam logic [5:0] OP_BNE   = 6'h05;
   localparam logic [5:0] OP_ADDIU = 6'h09;
   localparam logic [5:0] OP_SLTIU = 6'h0b;
   localparam logic [5:0] OP_ANDI  = 6'h0c;
   localparam logic [5:0] OP_ORI   = 6'h0d;
   localparam logic [5:0] OP_LUI   = 6'h0f;
   localparam logic [5:0] OP_LB    = 6'h20;
   localparam logic [5:0] OP_LW    = 6'h23;
   localparam logic [5:0] OP_SB    = 6'h28;
   localparam logic [5:0] OP_SW    = 6'h2b;

   // R-type function codes
   localparam logic [5:0] FN_SLL  = 6'h00;
   localparam logic [5:0] FN_SRL  = 6'h02;
   localparam logic [5:0] FN_JR   = 6'h08;
   localparam logic [5:0] FN_ADDU = 6'h21;
   localparam logic [5:0] FN_SUBU = 6'h23;
   localparam logic [5:0] FN_AND  = 6'h24;
   localparam logic [5:0] FN_OR   = 6'h25;
   localparam logic [5:0] FN_NOR  = 6'h27;
   localparam logic [5:0] FN_SLTU = 6'h2b;

   // Configuration register indexes
   localparam logic CSR_RESET_PC  = 1'b0;
   localparam logic CSR_DATA_BASE = 1'b1;

   // Register reset values
   localparam logic [31:0] RESET_PC_DEFAULT  = 32'h0040_0000;
   localparam logic [31:0] DATA_BASE_DEFAULT = 32'h1000_0000;

   localparam int unsigned RSP_WIDTH = 144;

   // Result of one instruction as held in the output stage
   typedef struct packed {
      logic [31:0] pc_next;
      logic        reg_write;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_write;
      logic [31:0] mem_address;
      logic [31:0] mem_data;
      logic        mem_is_byte;
      logic        outside_window;
      logic        bad_instr;
      logic        is_load;
   } exec_type;

endpackage

### rtl/core/mse_ram.sv
// Generic single-write, single-read RAM with bit write mask and registered read.
// No dependencies; used for the register file and the data window.
module mse_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [WIDTH-1:0]         wr_mask,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // masked write, read returns the contents before this edge's write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= (mem[wr_addr] & ~wr_mask) | (wr_data & wr_mask);
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/mips_subset_execute.sv
// MIPS32 subset execute core: one instruction word in, one retirement record out.
// Path: an accepted word passes the input, execute and result registers in turn before
// rsp_tvalid rises; one instruction per cycle sustained while rsp_tready is high, set by the
// single execute stage (PC update and operand forwarding loop).
// Reset: PC and data base return to their reset values and the register file reads as zero;
// the data window is then cleared in a pass over its DATA_WORDS words with req_tready low.
module mips_subset_execute #(
   parameter int unsigned DATA_WORDS = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   // instruction channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,   // instr_word
   // retirement channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // pc_next, reg_write, reg_index, reg_value, mem_write, mem_address, mem_data,
   // mem_is_byte, outside_window, bad_instr, zero fill
   output logic [mse_pkg::RSP_WIDTH-1:0] rsp_tdata,
   // configuration write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic                         csr_index,
   input  logic [31:0]                  csr_data
);
   import mse_pkg::*;
   `include "assert_macros.svh"

   localparam int unsigned AW = $clog2(DATA_WORDS);
   localparam logic [31:0] WIN_BYTES = 32'(DATA_WORDS * 4);
   localparam logic [AW:0] CLR_END = (AW + 1)'(DATA_WORDS);

   // configuration and architectural PC
   logic [31:0] data_base_ff;
   logic [31:0] pc_ff;

   // clearing pass over the data window
   logic [AW:0] clr_cnt_ff;
   logic        clr_busy;

   // pipeline stages
   logic        a_valid_ff, b_valid_ff, c_valid_ff;
   logic [31:0] a_instr_ff, b_instr_ff;
   exec_type    c_ff, b_res;
   logic        a_en, b_en, c_en, req_fire, b_fire;

   // register file read side
   logic [31:0] nxt_instr;
   logic [31:0] rf_rd_a, rf_rd_b;
   logic [31:0] rf_ok_ff;
   logic        rs_ok_ff, rt_ok_ff;
   logic        byp_we_ff;
   logic [4:0]  byp_idx_ff;
   logic [31:0] byp_val_ff;
   logic        rf_we;
   logic [31:0] c_reg_value;

   // execute stage signals
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [15:0] imm;
   logic [31:0] simm, opa, opb, pc4, ea, off, br_tgt, j_tgt;
   logic        in_win, is_store;
   logic [4:0]  lane_sh;

   // data window ports
   logic          dm_we, dm_re;
   logic [AW-1:0] dm_waddr;
   logic [31:0]   dm_wdata, dm_wmask, dm_rd, st_data, st_mask;
   logic [31:0]   load_val;
   logic [7:0]    load_byte;

   assign csr_ready = 1'b1;
   assign clr_busy  = (clr_cnt_ff != CLR_END);

   // stage enables: each stage moves when the one after it can take the item
   assign c_en       = !c_valid_ff || rsp_tready;
   assign b_en       = !b_valid_ff || c_en;
   assign a_en       = !a_valid_ff || b_en;
   assign req_tready = a_en && !clr_busy;
   assign req_fire   = req_tvalid && req_tready;
   assign b_fire     = b_valid_ff && c_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_en) a_valid_ff <= req_fire;
         if (b_en) b_valid_ff <= a_valid_ff;
         if (c_en) c_valid_ff <= b_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (req_fire) a_instr_ff <= req_tdata;
      if (b_en) b_instr_ff <= a_instr_ff;
      if (b_fire) c_ff <= b_res;
   end

   // configuration, PC and clearing counter
   always_ff @(posedge clock) begin
      if (reset) begin
         data_base_ff <= DATA_BASE_DEFAULT;
         pc_ff        <= RESET_PC_DEFAULT;
         clr_cnt_ff   <= '0;
      end else begin
         if (clr_busy) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (csr_valid && csr_ready && csr_index == CSR_DATA_BASE) data_base_ff <= csr_data;
         if (csr_valid && csr_ready && csr_index == CSR_RESET_PC) begin
            pc_ff <= csr_data;
         end else if (b_fire) begin
            pc_ff <= b_res.pc_next;
         end
      end
   end

   // register file: read every cycle for the instruction in execute next cycle
   assign nxt_instr = b_en ? a_instr_ff : b_instr_ff;
   assign rf_we     = c_valid_ff && rsp_tready && c_ff.reg_write;

   mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock  (clock),
      .wr_en  (rf_we),
      .wr_addr(c_ff.reg_index),
      .wr_data(c_reg_value),
      .wr_mask('1),
      .rd_en  (1'b1),
      .rd_addr(nxt_instr[25:21]),
      .rd_data(rf_rd_a)
   );

   mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock  (clock),
      .wr_en  (rf_we),
      .wr_addr(c_ff.reg_index),
      .wr_data(c_reg_value),
      .wr_mask('1),
      .rd_en  (1'b1),
      .rd_addr(nxt_instr[20:16]),
      .rd_data(rf_rd_b)
   );

   // written flags and a one-beat bypass of the write the read just missed
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_ok_ff  <= '0;
         byp_we_ff <= 1'b0;
      end else begin
         if (rf_we) rf_ok_ff[c_ff.reg_index] <= 1'b1;
         byp_we_ff <= rf_we;
      end
   end

   always_ff @(posedge clock) begin
      rs_ok_ff   <= rf_ok_ff[nxt_instr[25:21]];
      rt_ok_ff   <= rf_ok_ff[nxt_instr[20:16]];
      byp_idx_ff <= c_ff.reg_index;
      byp_val_ff <= c_reg_value;
   end

   // instruction fields
   assign op  = b_instr_ff[31:26];
   assign rs  = b_instr_ff[25:21];
   assign rt  = b_instr_ff[20:16];
   assign rd  = b_instr_ff[15:11];
   assign sh  = b_instr_ff[10:6];
   assign fn  = b_instr_ff[5:0];
   assign imm = b_instr_ff[15:0];

   // operands: output stage first, then the bypass, then the register file
   always_comb begin
      if (c_valid_ff && c_ff.reg_write && c_ff.reg_index == rs) opa = c_reg_value;
      else if (byp_we_ff && byp_idx_ff == rs)                   opa = byp_val_ff;
      else if (rs_ok_ff)                                        opa = rf_rd_a;
      else                                                      opa = '0;
      if (c_valid_ff && c_ff.reg_write && c_ff.reg_index == rt) opb = c_reg_value;
      else if (byp_we_ff && byp_idx_ff == rt)                   opb = byp_val_ff;
      else if (rt_ok_ff)                                        opb = rf_rd_b;
      else                                                      opb = '0;
   end

   // address arithmetic
   assign simm    = {{16{imm[15]}}, imm};
   assign pc4     = pc_ff + 32'd4;
   assign br_tgt  = pc4 + {simm[29:0], 2'b00};
   assign j_tgt   = {pc4[31:28], b_instr_ff[25:0], 2'b00};
   assign ea      = opa + simm;
   assign off     = ea - data_base_ff;
   assign in_win  = (off < WIN_BYTES);
   assign lane_sh = {ea[1:0], 3'b000};
   assign st_mask = (op == OP_SB) ? (32'hFF00_0000 >> lane_sh) : '1;
   assign st_data = (op == OP_SB) ? ({opb[7:0], 24'h0} >> lane_sh) : opb;

   // decode and execute
   always_comb begin
      b_res         = '0;
      b_res.pc_next = pc4;
      is_store      = 1'b0;
      case (op)
         OP_RTYPE: begin
            b_res.reg_write = 1'b1;
            b_res.reg_index = rd;
            case (fn)
               FN_ADDU: b_res.reg_value = opa + opb;
               FN_AND:  b_res.reg_value = opa & opb;
               FN_NOR:  b_res.reg_value = ~(opa | opb);
               FN_OR:   b_res.reg_value = opa | opb;
               FN_SLTU: b_res.reg_value = {31'h0, opa < opb};
               FN_SLL:  b_res.reg_value = opb << sh;
               FN_SRL:  b_res.reg_value = opb >> sh;
               FN_SUBU: b_res.reg_value = opa - opb;
               FN_JR: begin
                  b_res.reg_write = 1'b0;
                  b_res.pc_next   = opa;
               end
               default: begin
                  b_res.reg_write = 1'b0;
                  b_res.bad_instr = 1'b1;
               end
            endcase
         end
         OP_J: b_res.pc_next = j_tgt;
         OP_JAL: begin
            b_res.pc_next   = j_tgt;
            b_res.reg_write = 1'b1;
            b_res.reg_index = 5'd31;
            b_res.reg_value = pc4;
         end
         OP_ADDIU: begin
            b_res.reg_write = 1'b1;
            b_res.reg_index = rt;
            b_res.reg_value = ea;
         end
         OP_ANDI: begin
            b_res.reg_write = 1'b1;
            b_res.reg_index = rt;
            b_res.reg_value = opa & {16'h0, imm};
         end
         OP_ORI: begin
            b_res.reg_write = 1'b1;
            b_res.reg_index = rt;
            b_res.reg_value = opa | {16'h0, imm};
         end
         OP_SLTIU: begin
            b_res.reg_write = 1'b1;
            b_res.reg_index = rt;
            b_res.reg_value = {31'h0, opa < simm};
         end
         OP_LUI: begin
            b_res.reg_write = 1'b1;
            b_res.reg_index = rt;
            b_res.reg_value = {imm, 16'h0};
         end
         OP_BEQ: if (opa == opb) b_res.pc_next = br_tgt;
         OP_BNE: if (opa != opb) b_res.pc_next = br_tgt;
         OP_LW, OP_LB: begin
            b_res.reg_write      = 1'b1;
            b_res.reg_index      = rt;
            b_res.is_load        = 1'b1;
            b_res.mem_address    = ea;
            b_res.mem_is_byte    = (op == OP_LB);
            b_res.outside_window = !in_win;
         end
         OP_SW, OP_SB: begin
            is_store             = 1'b1;
            b_res.mem_address    = ea;
            b_res.mem_is_byte    = (op == OP_SB);
            b_res.mem_data       = (op == OP_SB) ? {24'h0, opb[7:0]} : opb;
            b_res.mem_write      = in_win;
            b_res.outside_window = !in_win;
         end
         default: b_res.bad_instr = 1'b1;
      endcase
      if (b_res.bad_instr) b_res.pc_next = pc_ff;
      // register zero is never written
      if (!b_res.reg_write || b_res.reg_index == 5'd0) begin
         b_res.reg_write = 1'b0;
         b_res.reg_index = '0;
         b_res.reg_value = '0;
         b_res.is_load   = 1'b0;
      end
   end

   // data window: clearing pass has the write port until it finishes
   assign dm_we    = clr_busy || (b_fire && is_store && in_win);
   assign dm_waddr = clr_busy ? clr_cnt_ff[AW-1:0] : off[AW+1:2];
   assign dm_wdata = clr_busy ? '0 : st_data;
   assign dm_wmask = clr_busy ? '1 : st_mask;
   assign dm_re    = b_fire && b_res.is_load && in_win;

   mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
      .clock  (clock),
      .wr_en  (dm_we),
      .wr_addr(dm_waddr),
      .wr_data(dm_wdata),
      .wr_mask(dm_wmask),
      .rd_en  (dm_re),
      .rd_addr(off[AW+1:2]),
      .rd_data(dm_rd)
   );

   // load data, big-endian byte lanes
   always_comb begin
      case (c_ff.mem_address[1:0])
         2'd0:    load_byte = dm_rd[31:24];
         2'd1:    load_byte = dm_rd[23:16];
         2'd2:    load_byte = dm_rd[15:8];
         default: load_byte = dm_rd[7:0];
      endcase
      if (c_ff.outside_window)   load_val = '0;
      else if (c_ff.mem_is_byte) load_val = {{24{load_byte[7]}}, load_byte};
      else                       load_val = dm_rd;
   end

   assign c_reg_value = c_ff.is_load ? load_val : c_ff.reg_value;

   // result beat
   assign rsp_tvalid = c_valid_ff;
   assign rsp_tdata  = {6'h0, c_ff.bad_instr, c_ff.outside_window, c_ff.mem_is_byte,
                        c_ff.mem_data, c_ff.mem_address, c_ff.mem_write, c_reg_value,
                        c_ff.reg_index, c_ff.reg_write, c_ff.pc_next};

   // checks
   `CHK_SAME(a_no_accept_in_clear, clr_busy, !req_tready)
   `CHK_SAME(a_bad_has_no_effect, c_valid_ff && c_ff.bad_instr, !c_ff.reg_write && !c_ff.mem_write)
   `CHK_SAME(a_store_in_window, b_fire && is_store && !clr_busy, dm_we == in_win)
   `CHK_NEXT(a_load_read_once, dm_re, c_valid_ff && c_ff.is_load)

endmodule
